// ----- hdl/fpmt_pkg.sv -----
// ----------------------------------------------------------------------------
// fpmt_pkg: shared types and constants of the prefix maximum table
// Field widths, command codes, the stored node word and the control and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fpmt_pkg;

  localparam int unsigned CmdW         = 2;
  localparam int unsigned PosW         = 11;
  localparam int unsigned ValueW       = 48;
  localparam int unsigned TagW         = 32;
  localparam int unsigned MaxPositions = 1024;
  localparam logic [PosW-1:0] SizeReset = PosW'(1024);

  typedef enum logic [CmdW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_QUERY  = 2'd2
  } fpmt_op_e;

  // One tree node: the valid flag and the (value, tag) pair.
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
    logic signed [TagW-1:0]   tag;
  } fpmt_node_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // latch a new item and set up its walk
    logic walk;      // step the index chain by one node
    logic clear;     // write one empty node of the clearing sweep
    logic out_load;  // move the result into the output register
  } fpmt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic chain_done;  // no node left to read and no read in flight
    logic clear_last;  // the sweep writes its last node this cycle
  } fpmt_sts_t;

  // Lexicographic order: signed value first, signed tag breaks ties.
  function automatic logic pair_greater(logic signed [ValueW-1:0] va,
                                        logic signed [TagW-1:0]   ta,
                                        logic signed [ValueW-1:0] vb,
                                        logic signed [TagW-1:0]   tb);
    logic res;
    if (va != vb) begin
      res = (va > vb);
    end else begin
      res = (ta > tb);
    end
    return res;
  endfunction

endpackage

// ----- hdl/fpmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpmt_ctrl: sequencer of the prefix maximum table
// Runs the clearing sweep, the index chain walk and the hand-off of each
// result to the output register.
// ----------------------------------------------------------------------------
module fpmt_ctrl
  import fpmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [CmdW-1:0]     op_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output fpmt_cmd_t           cmd_o,
  input  fpmt_sts_t           sts_i
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } fpmt_state_e;

  fpmt_state_e state_q, state_d;
  logic        init_q, init_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          init_d  = 1'b0;
          // The sweep after reset answers nothing; a clear command does.
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.start = 1'b1;
          state_d     = (op_i == OP_CLEAR) ? ST_CLEAR : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.chain_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("fpmt_ctrl: result loaded over a pending transfer");

  // The end of a commanded clear always produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clear_last && !init_q) |=> (state_q == ST_DONE))
    else $error("fpmt_ctrl: clear command finished without a result");

endmodule

// ----- hdl/fpmt_dp.sv -----
// ----------------------------------------------------------------------------
// fpmt_dp: datapath of the prefix maximum table
// Node memory, index chain register, pair comparison, running best and the
// output register.
// ----------------------------------------------------------------------------
module fpmt_dp
  import fpmt_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MaxPositions
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpmt_cmd_t                cmd_i,
  output fpmt_sts_t                sts_o,
  input  logic [PosW-1:0]          size_cfg_i,
  input  logic [CmdW-1:0]          op_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic signed [TagW-1:0]   tag_i,
  output fpmt_node_t               result_o
);

  localparam int unsigned IdxW = $clog2(MAX_POSITIONS + 1);
  localparam int unsigned CntW = ((IdxW > PosW) ? IdxW : PosW) + 1;
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_POSITIONS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_POSITIONS);

  // Node 0 is never used by the chain but keeps indexing direct.
  fpmt_node_t node_mem_q [MAX_POSITIONS+1];
  fpmt_node_t rd_data_q;

  logic [CntW-1:0] size;
  logic [CntW-1:0] pos_ext;
  logic [CntW-1:0] walk_q, walk_d;
  logic [CntW-1:0] low_bit;
  logic            active;
  logic            upd_q;
  logic            rd_valid_q, rd_valid_d;
  logic [IdxW-1:0] rd_addr_q;
  logic [IdxW-1:0] clr_addr_q, clr_addr_d;
  fpmt_node_t      key_q;
  fpmt_node_t      best_q, best_d;
  fpmt_node_t      out_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  fpmt_node_t      mem_wdata;

  assign size    = ({1'b0, size_cfg_i} > MaxCnt) ? MaxCnt : CntW'(size_cfg_i);
  assign pos_ext = CntW'(position_i);
  assign active  = (walk_q != '0) && (walk_q <= size);
  assign low_bit = walk_q & (~walk_q + CntW'(1));

  always_comb begin
    walk_d     = walk_q;
    rd_valid_d = cmd_i.walk && active;
    if (cmd_i.start) begin
      unique case (op_i)
        OP_UPDATE: walk_d = pos_ext;
        OP_QUERY:  walk_d = (pos_ext > size) ? size : pos_ext;
        default:   walk_d = '0;
      endcase
    end else if (cmd_i.walk && active) begin
      walk_d = upd_q ? (walk_q + low_bit) : (walk_q - low_bit);
    end
  end

  // Clear the best on a start, write the sweep node on a clear, else fold the node read in the previous cycle.
  always_comb begin
    best_d    = best_q;
    mem_we    = 1'b0;
    mem_waddr = clr_addr_q;
    mem_wdata = '0;
    if (cmd_i.start) begin
      best_d = '0;
    end else if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (rd_valid_q) begin
      if (upd_q) begin
        if (!rd_data_q.valid ||
            pair_greater(key_q.value, key_q.tag, rd_data_q.value, rd_data_q.tag)) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q;
          mem_wdata = key_q;
        end
      end else if (rd_data_q.valid &&
                   (!best_q.valid ||
                    pair_greater(rd_data_q.value, rd_data_q.tag,
                                 best_q.value, best_q.tag))) begin
        best_d = rd_data_q;
      end
    end
  end

  always_comb begin
    clr_addr_d = clr_addr_q;
    if (cmd_i.clear) begin
      clr_addr_d = (clr_addr_q == LastIdx) ? '0 : clr_addr_q + IdxW'(1);
    end
  end

  assign sts_o.chain_done = !active && !rd_valid_q;
  assign sts_o.clear_last = cmd_i.clear && (clr_addr_q == LastIdx);
  assign result_o         = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_valid_d) begin
      rd_data_q <= node_mem_q[walk_q[IdxW-1:0]];
      rd_addr_q <= walk_q[IdxW-1:0];
    end
    if (cmd_i.start) begin
      upd_q       <= (op_i == OP_UPDATE);
      key_q.valid <= 1'b1;
      key_q.value <= value_i;
      key_q.tag   <= tag_i;
    end
    if (cmd_i.out_load) begin
      out_q <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q     <= '0;
      rd_valid_q <= 1'b0;
      clr_addr_q <= '0;
      best_q     <= '0;
    end else begin
      walk_q     <= walk_d;
      rd_valid_q <= rd_valid_d;
      clr_addr_q <= clr_addr_d;
      best_q     <= best_d;
    end
  end

  // Every node read by a walk lies inside the active range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> (rd_addr_q != '0 && CntW'(rd_addr_q) <= size))
    else $error("fpmt_dp: chain read outside the active range");

  // The sweep never shares the write port with a pending write-back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !rd_valid_q)
    else $error("fpmt_dp: clearing sweep overlaps a chain read");

endmodule

// ----- hdl/fenwick_prefix_max_table.sv -----
// ----------------------------------------------------------------------------
// fenwick_prefix_max_table: prefix maximum table over (value, tag) pairs
// Binary indexed tree that answers the largest pair over positions 1..p.
// ----------------------------------------------------------------------------
// An update raises every node on the upward index chain from its position
// up to the active size; a query walks the downward chain from its prefix
// end and returns the largest pair, compared on the signed value first and
// the signed tag second. A clear command empties the table. Every command
// gives exactly one result transfer; update and clear results are all zero,
// as is a query that finds nothing. The nodes sit in a single memory with
// one registered read port and one write port, and the walk reads one node
// per cycle. A clear sweeps every memory entry, one per cycle. After reset
// the same sweep runs before the first input transfer is taken; the size
// register can be written during that time. A finished result waits in the
// output register, so the next item is taken while the previous result is
// still unclaimed.
// ----------------------------------------------------------------------------
module fenwick_prefix_max_table
  import fpmt_pkg::*;
#(
  parameter int unsigned MAX_POSITIONS = MaxPositions
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Active size register.
  input  logic            cfg_we_i,
  input  logic [PosW-1:0] cfg_wdata_i,
  // Input stream.
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [95:0]     s_axis_tdata,  // position [10:0], value [58:11], tag [90:59]
  input  logic [1:0]      s_axis_tuser,  // command [1:0]
  // Result stream.
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [79:0]     m_axis_tdata,  // best_value [47:0], best_tag [79:48]
  output logic [0:0]      m_axis_tuser   // found [0]
);

  logic [PosW-1:0] size_q;
  fpmt_cmd_t       cmd;
  fpmt_sts_t       sts;
  fpmt_node_t      result;

  // The user must change the size register only while no item is in flight; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  fpmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fpmt_dp #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .size_cfg_i (size_q),
    .op_i       (s_axis_tuser),
    .position_i (s_axis_tdata[10:0]),
    .value_i    (s_axis_tdata[58:11]),
    .tag_i      (s_axis_tdata[90:59]),
    .result_o   (result)
  );

  // A query that found nothing leaves the pair at zero, so no masking here.
  assign m_axis_tdata = {result.tag, result.value};
  assign m_axis_tuser = result.valid;

endmodule

// ----- tb/sv/tb_fenwick_prefix_max_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fenwick_prefix_max_table: self-checking bench for the prefix max table
// Streams clear, update and query commands into the table and checks every
// result transfer against a software copy of the tree, over several active
// sizes, with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_fenwick_prefix_max_table;
  import fpmt_pkg::*;

  // Command code that the block must ignore (it still answers with zeros).
  localparam logic [CmdW-1:0] OP_UNUSED = 2'd3;
  // Cycles without any transfer or register write before the run is abandoned.
  // The slowest legal stretch is a clear sweep plus a receiver stall, so this
  // leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned RANDOM_PER_PHASE = 70;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [PosW-1:0]          pos;
    logic signed [ValueW-1:0] val;
    logic signed [TagW-1:0]   tag;
  } table_cmd_t;

  typedef struct packed {
    logic                     found;
    logic signed [ValueW-1:0] val;
    logic signed [TagW-1:0]   tag;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [PosW-1:0]  cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [95:0]      s_axis_tdata = '0;   // position [10:0], value [58:11], tag [90:59]
  logic [1:0]       s_axis_tuser = '0;   // command [1:0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [79:0]      m_axis_tdata;        // best_value [47:0], best_tag [79:48]
  logic [0:0]       m_axis_tuser;        // found [0]

  fenwick_prefix_max_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Software copy of the tree. Index 0 is never touched by a walk.
  // --------------------------------------------------------------------------
  logic signed [ValueW-1:0] node_val [0:MaxPositions];
  logic signed [TagW-1:0]   node_tag [0:MaxPositions];
  bit                       node_ok  [0:MaxPositions];
  logic [PosW-1:0]          active_size_copy = SizeReset;

  table_cmd_t cmd_backlog[$];
  answer_t    expected_answers[$];
  int unsigned mismatch_count = 0;

  // Lexicographic order on signed (value, tag): flipping the sign bits turns
  // the pair into one unsigned key.
  function automatic bit pair_above(logic signed [ValueW-1:0] va, logic signed [TagW-1:0] ta,
                                    logic signed [ValueW-1:0] vb, logic signed [TagW-1:0] tb);
    return {~va[ValueW-1], va[ValueW-2:0], ~ta[TagW-1], ta[TagW-2:0]} >
           {~vb[ValueW-1], vb[ValueW-2:0], ~tb[TagW-1], tb[TagW-2:0]};
  endfunction

  // Applies one command to the tree copy and returns the answer it produces.
  function automatic answer_t predict_prefix_max(table_cmd_t c);
    answer_t     a;
    int unsigned i;
    int unsigned lim;
    a = '0;
    lim = 32'(active_size_copy);
    if (lim > MaxPositions) lim = MaxPositions;
    case (c.cmd)
      OP_CLEAR: begin
        foreach (node_ok[k]) node_ok[k] = 1'b0;
      end
      OP_UPDATE: begin
        i = 32'(c.pos);
        while (i != 0 && i <= lim) begin
          if (!node_ok[i] || pair_above(c.val, c.tag, node_val[i], node_tag[i])) begin
            node_val[i] = c.val;
            node_tag[i] = c.tag;
            node_ok[i]  = 1'b1;
          end
          i += i & (~i + 1);
        end
      end
      OP_QUERY: begin
        i = (32'(c.pos) > lim) ? lim : 32'(c.pos);
        while (i != 0) begin
          if (node_ok[i] && (!a.found || pair_above(node_val[i], node_tag[i], a.val, a.tag))) begin
            a.found = 1'b1;
            a.val   = node_val[i];
            a.tag   = node_tag[i];
          end
          i -= i & (~i + 1);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void push_cmd(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                   logic signed [ValueW-1:0] val, logic signed [TagW-1:0] tag);
    table_cmd_t item;
    item.cmd = cmd;
    item.pos = pos;
    item.val = val;
    item.tag = tag;
    cmd_backlog.insert(cmd_backlog.size(), item);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. The prediction
  // is made at the edge where the transfer happens, so it follows the order
  // in which the block takes the commands.
  // --------------------------------------------------------------------------
  table_cmd_t  cur_cmd;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_answers.insert(expected_answers.size(), predict_prefix_max(cur_cmd));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, cur_cmd.tag, cur_cmd.val, cur_cmd.pos};
          s_axis_tuser  <= cur_cmd.cmd;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transfer, then picks the ready for the next
  // cycle from one of four stall modes that change every so often.
  // --------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned pattern_cnt = 0;

  always @(posedge clk_i) begin : result_check
    answer_t got;
    answer_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser[0];
        got.val   = m_axis_tdata[ValueW-1:0];
        got.tag   = m_axis_tdata[ValueW+TagW-1:ValueW];
        if (expected_answers.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result found=%0b value=%0d tag=%0d",
                     $realtime, got.found, got.val, got.tag);
          end
        end else begin
          want = expected_answers.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch, expected found=%0b value=%0d tag=%0d, got found=%0b value=%0d tag=%0d",
                       $realtime, want.found, want.val, want.tag, got.found, got.val, got.tag);
            end
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      pattern_cnt++;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= (pattern_cnt % 12 == 0);
      endcase
    end
  end

  // Watchdog on cycles in which nothing moves.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Returns once every command has been taken and every answer has come back.
  // Sampling at the falling edge keeps clear of the driver and monitor.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || s_axis_tvalid || expected_answers.size() != 0);
  endtask

  // The block is idle here, since every command answers only after its work.
  task automatic set_active_size(logic [PosW-1:0] sz);
    wait_drained();
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sz;
    active_size_copy = sz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  localparam logic signed [ValueW-1:0] VMAX = {1'b0, {(ValueW-1){1'b1}}};
  localparam logic signed [ValueW-1:0] VMIN = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [TagW-1:0]   TMAX = {1'b0, {(TagW-1){1'b1}}};
  localparam logic signed [TagW-1:0]   TMIN = {1'b1, {(TagW-1){1'b0}}};

  int unsigned size_plan [9] = '{1, 2047, 0, 7, 1024, 100, 1500, 16, 0};

  initial begin : stimulus
    table_cmd_t  c;
    int unsigned lim;
    int unsigned r;
    foreach (node_ok[k]) node_ok[k] = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset size of 1024: empty table, position zero,
    // positions past the size, the value and tag extremes, ties broken by
    // the tag, a clear, and the unused command code.
    push_cmd(OP_QUERY, 11'd1, '0, '0);
    push_cmd(OP_QUERY, 11'd0, '0, '0);
    push_cmd(OP_UPDATE, 11'd0, VMAX, TMAX);
    push_cmd(OP_QUERY, 11'd2047, '0, '0);
    push_cmd(OP_UPDATE, 11'd1, VMAX, TMAX);
    push_cmd(OP_UPDATE, 11'd1024, VMIN, TMIN);
    push_cmd(OP_UPDATE, 11'd1025, VMAX, TMAX);
    push_cmd(OP_UPDATE, 11'd2047, VMAX, TMAX);
    push_cmd(OP_QUERY, 11'd1024, '0, '0);
    push_cmd(OP_QUERY, 11'd2047, '0, '0);
    push_cmd(OP_QUERY, 11'd512, '0, '0);
    push_cmd(OP_CLEAR, 11'd0, '0, '0);
    push_cmd(OP_QUERY, 11'd1024, '0, '0);
    push_cmd(OP_UPDATE, 11'd3, 48'sd5, -32'sd1);
    push_cmd(OP_UPDATE, 11'd2, 48'sd5, 32'sd7);
    push_cmd(OP_UPDATE, 11'd5, 48'sd5, TMIN);
    push_cmd(OP_QUERY, 11'd3, '0, '0);
    push_cmd(OP_QUERY, 11'd4, '0, '0);
    push_cmd(OP_QUERY, 11'd6, '0, '0);
    push_cmd(OP_UPDATE, 11'd6, -48'sd1, TMAX);
    push_cmd(OP_QUERY, 11'd6, '0, '0);
    push_cmd(OP_UNUSED, 11'd2047, VMIN, TMAX);
    push_cmd(OP_QUERY, 11'd1, '0, '0);
    push_cmd(OP_UPDATE, 11'd1024, VMIN, 32'sd0);
    push_cmd(OP_QUERY, 11'd1023, '0, '0);
    push_cmd(OP_QUERY, 11'd1024, '0, '0);

    // Random phases over several sizes, including zero and values above the
    // table depth. Phases without a clear leave nodes above a reduced size.
    size_plan[8] = $urandom_range(1, 2047);
    foreach (size_plan[ph]) begin
      set_active_size(PosW'(size_plan[ph]));
      lim = (size_plan[ph] > MaxPositions) ? MaxPositions : size_plan[ph];
      repeat (RANDOM_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 2)       c.cmd = OP_CLEAR;
        else if (r < 4)  c.cmd = OP_UNUSED;
        else if (r < 52) c.cmd = OP_UPDATE;
        else             c.cmd = OP_QUERY;
        case ($urandom_range(0, 15))
          0: c.pos = '0;
          1: c.pos = PosW'($urandom_range(0, 2047));
          2: c.pos = PosW'(lim);
          3: c.pos = PosW'(lim + 1);
          default: c.pos = PosW'((lim == 0) ? $urandom_range(0, 3) : $urandom_range(1, lim));
        endcase
        // Small pools make equal values common, so the tag often decides.
        case ($urandom_range(0, 5))
          0: c.val = VMAX;
          1: c.val = VMIN;
          2, 3: c.val = 48'($urandom_range(0, 4)) - 48'd2;
          default: c.val = {16'($urandom()), 32'($urandom())};
        endcase
        case ($urandom_range(0, 4))
          0: c.tag = TMAX;
          1: c.tag = TMIN;
          2, 3: c.tag = 32'($urandom_range(0, 3)) - 32'd1;
          default: c.tag = $urandom();
        endcase
        push_cmd(c.cmd, c.pos, c.val, c.tag);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
